FILE: sv/shooting_rk4_oscillator_bvp_defines.svh
// ----------------------------------------------------------------------------
// shooting_rk4_oscillator_bvp_defines
// assertion macros used by the checker file of the shooting solver
// ----------------------------------------------------------------------------
`ifndef SHOOTING_RK4_OSCILLATOR_BVP_DEFINES_SVH
`define SHOOTING_RK4_OSCILLATOR_BVP_DEFINES_SVH

// property sampled on clk, off while rst_n is low
`define SRK4_ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define SRK4_ASSERT_NEXT(label, ante, cons, msg) \
  `SRK4_ASSERT_IMPL(label, (ante) |=> (cons), msg)

`endif

FILE: sv/srk4_pkg.sv
// ----------------------------------------------------------------------------
// srk4_pkg
// types, constants and saturating helpers of the shooting solver
// ----------------------------------------------------------------------------
`default_nettype none

package srk4_pkg;

  localparam int MAX_STEPS = 32;
  localparam int FRAC_BITS = 16;
  localparam int D6_ITERS  = 4;
  localparam int D6_BITS   = 9;
  localparam int DIV_BITS  = 64;

  // register indexes on the config port
  localparam logic [1:0] REG_START_X    = 2'd0;
  localparam logic [1:0] REG_STEP_SIZE  = 2'd1;
  localparam logic [1:0] REG_STEP_COUNT = 2'd2;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  typedef enum logic [1:0] {
    PASS_A,
    PASS_B,
    PASS_C
  } pass_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_INIT,
    OP_MUL,
    OP_UPD,
    OP_D6_LOAD,
    OP_D6_ITER,
    OP_STEP_FIN,
    OP_SAVE_END,
    OP_SEC_MUL,
    OP_DIV_GO,
    OP_SEC_FIN,
    OP_EMIT_SLOPE,
    OP_EMIT_POINT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_MUL,
    S_UPD,
    S_D6_LOAD,
    S_D6_ITER,
    S_STEP_FIN,
    S_PASS_END,
    S_SEC_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SEC_FIN,
    S_EMIT_SLOPE,
    S_EMIT_PT
  } state_t;

  typedef struct packed {
    op_t        op;
    pass_t      pass;
    logic [1:0] stage;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_busy;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > S32_MAX) return 32'sh7fffffff;
    if (v < S32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32({{34{a[31]}}, a} + {{34{b[31]}}, b});
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32({{34{a[31]}}, a} - {{34{b[31]}}, b});
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    return (a == 32'sh80000000) ? 32'sh7fffffff : -a;
  endfunction

  // round half up, floor by 2^FRAC_BITS, saturate
  function automatic logic signed [31:0] rnd_mul(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (64'sd1 <<< (FRAC_BITS - 1));
    t = t >>> FRAC_BITS;
    return sat32({{2{t[63]}}, t});
  endfunction

endpackage

`default_nettype wire

FILE: sv/srk4_div.sv
// ----------------------------------------------------------------------------
// srk4_div
// serial signed divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module srk4_div import srk4_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               busy,
  output logic signed [63:0] quo
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [31:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] trial;

  // restoring step on magnitudes
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    trial    = {rem_r[31:0], q_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = num[63] ? 64'(-num) : 64'(num);
      d_nxt    = den[31] ? 32'(-den) : 32'(den);
      neg_nxt  = num[63] ^ den[31];
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_BITS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

`default_nettype wire

FILE: sv/srk4_dp.sv
// ----------------------------------------------------------------------------
// srk4_dp
// datapath: rk4 stage arithmetic, divide-by-six unit, secant and output word
// ----------------------------------------------------------------------------
`default_nettype none

module srk4_dp import srk4_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_slope_a,
  input  logic signed [31:0] in_slope_b,
  input  logic signed [31:0] start_x,
  input  logic [30:0]        step_size,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_slope,
  output logic               out_err,
  output logic               out_last
);

  localparam logic [35:0]        D6_OFS  = 36'h600000000;
  localparam logic signed [35:0] D6_BIAS = 36'sh200000000;

  // item and integrator state
  logic signed [31:0] sy_r, tgt_r, za_r, zb_r;
  logic signed [31:0] y_r, z_r, x_r, yt_r, zt_r;
  logic signed [63:0] pk_r, pl_r;
  logic signed [34:0] ay_r, az_r;
  logic [35:0]        vy_r, vz_r;
  logic [1:0]         ry_r, rz_r;
  logic signed [31:0] ea_r, eb_r, slope_r;
  logic signed [63:0] sp_r;
  logic signed [31:0] dd_r;
  logic               err_r;
  logic               ov_r;
  logic               ok_r, ol_r, oe_r;
  logic signed [31:0] ox_r, oy_r, os_r;

  logic signed [31:0] k, l, khalf, lhalf;
  logic signed [34:0] k35, l35, ty, tz, uy, uz;
  logic signed [35:0] dy, dz6;
  logic [37:0]        sy3, sz3;
  logic signed [63:0] quo;
  logic               div_busy;
  logic signed [31:0] pass_slope;
  logic signed [31:0] ynew, znew;
  logic signed [31:0] sdz, sdn, sdd;
  logic signed [31:0] sec_slope;

  // nine quotient bits of a divide by three, remainder kept narrow
  function automatic logic [37:0] div3_step(input logic [35:0] v, input logic [1:0] r);
    logic [35:0] vv;
    logic [1:0]  rr;
    logic [2:0]  r3;
    vv = v;
    rr = r;
    for (int j = 0; j < D6_BITS; j++) begin
      r3 = {rr, vv[35]};
      vv = {vv[34:0], 1'b0};
      if (r3 >= 3'd3) begin
        r3    = r3 - 3'd3;
        vv[0] = 1'b1;
      end
      rr = r3[1:0];
    end
    return {rr, vv};
  endfunction

  srk4_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV_GO),
    .num   (sp_r),
    .den   (dd_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  // stage results from the registered products
  always_comb begin
    k     = rnd_mul(pk_r);
    l     = rnd_mul(pl_r);
    k35   = {{3{k[31]}}, k};
    l35   = {{3{l[31]}}, l};
    khalf = k >>> 1;
    lhalf = l >>> 1;
    ty    = ay_r + 35'sd3;
    tz    = az_r + 35'sd3;
    uy    = ty >>> 1;
    uz    = tz >>> 1;
    sy3   = div3_step(vy_r, ry_r);
    sz3   = div3_step(vz_r, rz_r);
    dy    = $signed(vy_r) - D6_BIAS;
    dz6   = $signed(vz_r) - D6_BIAS;
    ynew  = sat32({{30{dy[35]}}, dy} + {{34{y_r[31]}}, y_r});
    znew  = sat32({{30{dz6[35]}}, dz6} + {{34{z_r[31]}}, z_r});
    sdz   = sub_sat(zb_r, za_r);
    sdn   = sub_sat(tgt_r, ea_r);
    sdd   = sub_sat(eb_r, ea_r);
    sec_slope = sat32({{2{quo[63]}}, quo} + {{34{za_r[31]}}, za_r});
    case (cmd.pass)
      PASS_A:  pass_slope = za_r;
      PASS_B:  pass_slope = zb_r;
      default: pass_slope = slope_r;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        sy_r  <= in_start_y;
        tgt_r <= in_target_y;
        za_r  <= in_slope_a;
        zb_r  <= in_slope_b;
      end
      OP_INIT: begin
        x_r  <= start_x;
        y_r  <= sy_r;
        yt_r <= sy_r;
        z_r  <= pass_slope;
        zt_r <= pass_slope;
      end
      OP_MUL: begin
        pk_r <= $signed({1'b0, step_size}) * zt_r;
        pl_r <= $signed({1'b0, step_size}) * neg_sat(yt_r);
      end
      OP_UPD: begin
        case (cmd.stage)
          2'd0: begin
            ay_r <= k35;
            az_r <= l35;
          end
          2'd3: begin
            ay_r <= ay_r + k35;
            az_r <= az_r + l35;
          end
          default: begin
            ay_r <= ay_r + (k35 <<< 1);
            az_r <= az_r + (l35 <<< 1);
          end
        endcase
        if (cmd.stage < 2'd2) begin
          yt_r <= add_sat(y_r, khalf);
          zt_r <= add_sat(z_r, lhalf);
        end else begin
          yt_r <= add_sat(y_r, k);
          zt_r <= add_sat(z_r, l);
        end
      end
      OP_D6_LOAD: begin
        vy_r <= {uy[34], uy} + D6_OFS;
        vz_r <= {uz[34], uz} + D6_OFS;
        ry_r <= '0;
        rz_r <= '0;
      end
      OP_D6_ITER: begin
        {ry_r, vy_r} <= sy3;
        {rz_r, vz_r} <= sz3;
      end
      OP_STEP_FIN: begin
        y_r  <= ynew;
        yt_r <= ynew;
        z_r  <= znew;
        zt_r <= znew;
        x_r  <= add_sat(x_r, $signed({1'b0, step_size}));
      end
      OP_SAVE_END: begin
        if (cmd.pass == PASS_A) ea_r <= y_r;
        else eb_r <= y_r;
      end
      OP_SEC_MUL: begin
        sp_r  <= sdz * sdn;
        dd_r  <= sdd;
        err_r <= (ea_r == eb_r);
      end
      OP_SEC_FIN: begin
        slope_r <= err_r ? zb_r : sec_slope;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == OP_EMIT_SLOPE || cmd.op == OP_EMIT_POINT) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT_SLOPE) begin
      ok_r <= 1'b0;
      ox_r <= '0;
      oy_r <= '0;
      os_r <= slope_r;
      oe_r <= err_r;
      ol_r <= 1'b0;
    end else if (cmd.op == OP_EMIT_POINT) begin
      ok_r <= 1'b1;
      ox_r <= x_r;
      oy_r <= y_r;
      os_r <= slope_r;
      oe_r <= err_r;
      ol_r <= cmd.last;
    end
  end

  assign sts.out_free = !ov_r || out_ready;
  assign sts.div_busy = div_busy;
  assign out_valid    = ov_r;
  assign out_kind     = ok_r;
  assign out_x        = ox_r;
  assign out_y        = oy_r;
  assign out_slope    = os_r;
  assign out_err      = oe_r;
  assign out_last     = ol_r;

endmodule

`default_nettype wire

FILE: sv/srk4_ctrl.sv
// ----------------------------------------------------------------------------
// srk4_ctrl
// sequencer for the two trial passes, the secant step and the output pass
// ----------------------------------------------------------------------------
`default_nettype none

module srk4_ctrl import srk4_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] step_count,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [5:0] N_MAX   = 6'(MAX_STEPS);
  localparam logic [1:0] D6_LAST = 2'(D6_ITERS - 1);

  state_t     state_r, state_nxt;
  pass_t      pass_r, pass_nxt;
  logic [5:0] i_r, i_nxt;
  logic [1:0] s_r, s_nxt;
  logic [1:0] c_r, c_nxt;
  logic [5:0] n;

  assign n = (step_count > N_MAX) ? N_MAX : step_count;

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    c_nxt     = c_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_INIT;
          pass_nxt  = PASS_A;
        end
      end
      S_INIT: begin
        i_nxt = '0;
        s_nxt = '0;
        if (pass_r == PASS_C) state_nxt = S_EMIT_PT;
        else if (n == '0) state_nxt = S_PASS_END;
        else state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_UPD;
      S_UPD: begin
        if (s_r == 2'd3) begin
          state_nxt = S_D6_LOAD;
        end else begin
          s_nxt     = s_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_D6_LOAD: begin
        c_nxt     = '0;
        state_nxt = S_D6_ITER;
      end
      S_D6_ITER: begin
        c_nxt = c_r + 2'd1;
        if (c_r == D6_LAST) state_nxt = S_STEP_FIN;
      end
      S_STEP_FIN: begin
        i_nxt = i_r + 6'd1;
        s_nxt = '0;
        if (pass_r == PASS_C) state_nxt = S_EMIT_PT;
        else if (i_r + 6'd1 == n) state_nxt = S_PASS_END;
        else state_nxt = S_MUL;
      end
      S_PASS_END: begin
        if (pass_r == PASS_A) begin
          pass_nxt  = PASS_B;
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_SEC_MUL;
        end
      end
      S_SEC_MUL:  state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (!sts.div_busy) state_nxt = S_SEC_FIN;
      S_SEC_FIN:  state_nxt = S_EMIT_SLOPE;
      S_EMIT_SLOPE: begin
        if (sts.out_free) begin
          pass_nxt  = PASS_C;
          state_nxt = S_INIT;
        end
      end
      S_EMIT_PT: begin
        if (sts.out_free) begin
          if (i_r == n) state_nxt = S_IDLE;
          else state_nxt = S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.pass  = pass_r;
    cmd.stage = s_r;
    cmd.last  = (i_r == n);
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LATCH;
      end
      S_INIT:       cmd.op = OP_INIT;
      S_MUL:        cmd.op = OP_MUL;
      S_UPD:        cmd.op = OP_UPD;
      S_D6_LOAD:    cmd.op = OP_D6_LOAD;
      S_D6_ITER:    cmd.op = OP_D6_ITER;
      S_STEP_FIN:   cmd.op = OP_STEP_FIN;
      S_PASS_END:   cmd.op = OP_SAVE_END;
      S_SEC_MUL:    cmd.op = OP_SEC_MUL;
      S_DIV_GO:     cmd.op = OP_DIV_GO;
      S_DIV_WAIT:   cmd.op = OP_NONE;
      S_SEC_FIN:    cmd.op = OP_SEC_FIN;
      S_EMIT_SLOPE: if (sts.out_free) cmd.op = OP_EMIT_SLOPE;
      S_EMIT_PT:    if (sts.out_free) cmd.op = OP_EMIT_POINT;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= PASS_A;
      i_r     <= '0;
      s_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      i_r     <= i_nxt;
      s_r     <= s_nxt;
      c_r     <= c_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/shooting_rk4_oscillator_bvp.sv
// ----------------------------------------------------------------------------
// shooting_rk4_oscillator_bvp
// shooting-method solver for y'' = -y with rk4 passes and a secant step
// ----------------------------------------------------------------------------
// usage:
//   in_* takes one problem word: start y, target y and two slope guesses,
//   all signed Q16.16. it is taken only while the solver is idle.
//   out_* gives one slope word (tuser 0) and then n+1 solution points
//   (tuser 1), the final point with tlast high. n is step_count, capped at 32.
//   cfg_* is a register port for start_x, step_size and step_count; write it
//   only while no problem is in flight.
// sequence:
//   each rk4 step runs four multiply/update stage pairs on two shared
//   multipliers, then the divide-by-six unit and a write-back; the secant
//   divider makes one quotient bit a cycle and then hands its result over.
//   problems are solved one at a time.
// reset:
//   rst_n low returns to idle, drops out_tvalid and restores register
//   defaults (start_x 0, step_size 6554, step_count 10).
// stalls:
//   a word waits in the output register while out_tready is low; the
//   sequencer holds until the register is free, nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module shooting_rk4_oscillator_bvp import srk4_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // start_y, target_y, slope_guess_a, slope_guess_b
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,   // x_value, y_value, slope_value, div_error, zero pad
  output logic         out_tuser,   // kind
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic signed [31:0] start_x_r;
  logic [30:0]        step_size_r;
  logic [5:0]         step_count_r;
  logic [1:0]         reg_idx;
  logic               cfg_wr;

  cmd_t               cmd;
  sts_t               sts;
  logic               o_kind, o_err, o_last;
  logic signed [31:0] o_x, o_y, o_slope;

  // register port
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      step_size_r  <= 31'd6554;
      step_count_r <= 6'd10;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_X:    start_x_r    <= cfg_pwdata;
        REG_STEP_SIZE:  step_size_r  <= cfg_pwdata[30:0];
        REG_STEP_COUNT: step_count_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_X:    cfg_prdata = start_x_r;
      REG_STEP_SIZE:  cfg_prdata = {1'b0, step_size_r};
      REG_STEP_COUNT: cfg_prdata = {26'd0, step_count_r};
      default:        cfg_prdata = '0;
    endcase
  end

  srk4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .step_count (step_count_r),
    .sts        (sts),
    .cmd        (cmd)
  );

  srk4_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_start_y  (in_tdata[31:0]),
    .in_target_y (in_tdata[63:32]),
    .in_slope_a  (in_tdata[95:64]),
    .in_slope_b  (in_tdata[127:96]),
    .start_x     (start_x_r),
    .step_size   (step_size_r),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (o_kind),
    .out_x       (o_x),
    .out_y       (o_y),
    .out_slope   (o_slope),
    .out_err     (o_err),
    .out_last    (o_last)
  );

  // result word packing
  assign out_tdata = {7'd0, o_err, o_slope, o_y, o_x};
  assign out_tuser = o_kind;
  assign out_tlast = o_last;

endmodule

`default_nettype wire

FILE: sv/srk4_checker.sv
// ----------------------------------------------------------------------------
// srk4_checker
// port-level checks of the shooting solver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "shooting_rk4_oscillator_bvp_defines.svh"

module srk4_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);

  // a stalled result word holds
  `SRK4_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output word changed")

  // one problem at a time: busy right after a word is taken
  `SRK4_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // the closing word of a run is a solution point
  `SRK4_ASSERT_IMPL(a_last_is_point, out_tvalid && out_tlast |-> out_tuser, "tlast on a slope word")

endmodule

bind shooting_rk4_oscillator_bvp srk4_checker u_srk4_checker (.*);

`default_nettype wire

FILE: bench/tb_shooting_rk4_oscillator_bvp.sv
// ----------------------------------------------------------------------------
// tb_shooting_rk4_oscillator_bvp
// self-checking bench: problem words in, slope word and rk4 solution points
// out, each word compared with a bit-exact fixed point solver model
// ----------------------------------------------------------------------------
`default_nettype none

module tb_shooting_rk4_oscillator_bvp import srk4_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic KIND_SLOPE = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef struct packed {
    logic signed [31:0] slope_b;
    logic signed [31:0] slope_a;
    logic signed [31:0] target_y;
    logic signed [31:0] start_y;
  } problem_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] slope_value;
    logic               div_error;
    logic               last;
  } solution_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  shooting_rk4_oscillator_bvp dut (.*);

  // model copy of the registers
  logic signed [31:0] m_start_x;
  logic [30:0]        m_step_size;
  logic [5:0]         m_step_count;

  problem_t  problem_q[$];
  solution_t solution_q[$];
  logic      in_taken;
  int        error_count;
  int        words_seen;
  int        problems_sent;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;
  int        idle_count;

  // ---------------------------------------------------------------- model
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint floor_div(input longint v, input longint d);
    longint q;
    q = v / d;
    if ((v % d != 0) && (v < 0)) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] hmul(input longint h, input longint v);
    return clamp32(floor_div(h * v + (64'sd1 << (FRAC_BITS - 1)), 64'sd1 << FRAC_BITS));
  endfunction

  // one rk4 step of y' = z, z' = -y
  function automatic void rk4_advance(inout logic signed [31:0] y,
                                      inout logic signed [31:0] z, input longint h);
    longint k1, k2, k3, k4, l1, l2, l3, l4, ya, za, yb, zb, yc, zc;
    k1 = hmul(h, z);
    l1 = hmul(h, clamp32(-longint'(y)));
    ya = clamp32(y + floor_div(k1, 2));
    za = clamp32(z + floor_div(l1, 2));
    k2 = hmul(h, za);
    l2 = hmul(h, clamp32(-ya));
    yb = clamp32(y + floor_div(k2, 2));
    zb = clamp32(z + floor_div(l2, 2));
    k3 = hmul(h, zb);
    l3 = hmul(h, clamp32(-yb));
    yc = clamp32(y + k3);
    zc = clamp32(z + l3);
    k4 = hmul(h, zc);
    l4 = hmul(h, clamp32(-yc));
    y = clamp32(y + floor_div(k1 + 2 * k2 + 2 * k3 + k4 + 3, 6));
    z = clamp32(z + floor_div(l1 + 2 * l2 + 2 * l3 + l4 + 3, 6));
  endfunction

  function automatic logic signed [31:0] shoot_end(input logic signed [31:0] y0,
                                                   input logic signed [31:0] s, input int n);
    logic signed [31:0] y, z;
    y = y0;
    z = s;
    for (int i = 0; i < n; i++) rk4_advance(y, z, m_step_size);
    return y;
  endfunction

  task automatic predict_solution(input problem_t p);
    int                 n;
    logic signed [31:0] end_a, end_b, slope, y, z, x;
    logic               err;
    longint             dz, dn, dd;
    solution_t          s;
    n = (m_step_count > MAX_STEPS) ? MAX_STEPS : m_step_count;
    end_a = shoot_end(p.start_y, p.slope_a, n);
    end_b = shoot_end(p.start_y, p.slope_b, n);
    err = (end_a == end_b);
    if (err) begin
      slope = p.slope_b;
    end else begin
      dz = clamp32(longint'(p.slope_b) - p.slope_a);
      dn = clamp32(longint'(p.target_y) - end_a);
      dd = clamp32(longint'(end_b) - end_a);
      slope = clamp32(p.slope_a + (dz * dn) / dd);
    end
    s = '{KIND_SLOPE, 32'sd0, 32'sd0, slope, err, 1'b0};
    solution_q.push_back(s);
    x = m_start_x;
    y = p.start_y;
    z = slope;
    for (int i = 0; i <= n; i++) begin
      s = '{KIND_POINT, x, y, slope, err, i == n};
      solution_q.push_back(s);
      if (i < n) begin
        rk4_advance(y, z, m_step_size);
        x = clamp32(longint'(x) + m_step_size);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, words_seen);
  endtask

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- driver
  // input handshake seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_taken) begin
        problems_sent++;
        predict_solution(problem_q.pop_front());
      end
      if (!in_tvalid || in_taken) begin
        if (problem_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= problem_q[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    solution_t got, want;
    if (rst_n && (in_tvalid && in_tready || out_tvalid && out_tready)) idle_count = 0;
    else idle_count++;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
              out_tdata[96], out_tlast};
      words_seen++;
      if (solution_q.size() == 0) begin
        report_mismatch("unexpected word", got.y_value, 32'd0);
      end else begin
        want = solution_q.pop_front();
        if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.x_value != want.x_value) report_mismatch("x", got.x_value, want.x_value);
        if (got.y_value != want.y_value) report_mismatch("y", got.y_value, want.y_value);
        if (got.slope_value != want.slope_value)
          report_mismatch("slope", got.slope_value, want.slope_value);
        if (got.div_error != want.div_error)
          report_mismatch("div_error", got.div_error, want.div_error);
        if (got.last != want.last) report_mismatch("last", got.last, want.last);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (idle_count > WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_START_X:    m_start_x = value;
      REG_STEP_SIZE:  m_step_size = value[30:0];
      REG_STEP_COUNT: m_step_count = value[5:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (problem_q.size() > 0 || in_tvalid || solution_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(3);
      2: return 32'sh80000000 + $urandom_range(3);
      default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic queue_problem(input logic signed [31:0] y0, input logic signed [31:0] yn,
                               input logic signed [31:0] sa, input logic signed [31:0] sb);
    problem_q.push_back('{sb, sa, yn, y0});
  endtask

  task automatic queue_random(input int count);
    logic signed [31:0] s;
    for (int i = 0; i < count; i++) begin
      s = rand_value();
      if ($urandom_range(9) == 0) queue_problem(rand_value(), rand_value(), s, s);
      else queue_problem(rand_value(), rand_value(), s, rand_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    m_start_x = 32'sd0;
    m_step_size = 31'd6554;
    m_step_count = 6'd10;
    error_count = 0;
    words_seen = 0;
    problems_sent = 0;
    hold_cycles = 0;
    idle_count = 0;
    send_idle_pct = 22;
    recv_idle_pct = 62;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: defaults, field extremes, equal guesses
    queue_problem(32'sh0001_0000, 32'sh0000_8000, 32'sh0001_0000, 32'sh0002_0000);
    queue_problem(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    queue_problem(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    queue_problem(32'sh0, 32'sh0, 32'sh0003_0000, 32'sh0003_0000);
    queue_problem(32'shffffffff, 32'sh1, 32'sh0, 32'shffffffff);
    wait_drained();
    // zero step count, zero step size, extreme start_x
    reg_write(REG_STEP_COUNT, 32'd0);
    reg_write(REG_START_X, 32'h7fff_fff0);
    queue_problem(32'sh0001_0000, 32'sh0002_0000, 32'sh1000, 32'sh2000);
    wait_drained();
    reg_write(REG_STEP_COUNT, 32'd63);
    reg_write(REG_STEP_SIZE, 32'd0);
    queue_problem(32'sh0001_0000, 32'sh0002_0000, 32'sh1000, 32'sh2000);
    wait_drained();
    reg_write(REG_STEP_SIZE, 32'h7fff_ffff);
    reg_write(REG_START_X, 32'h8000_0000);
    reg_write(REG_STEP_COUNT, 32'd2);
    queue_problem(32'sh0001_0000, 32'sh0002_0000, 32'sh1000, 32'sh2000);
    queue_problem(32'sh7fffffff, 32'sh0, 32'sh7fffffff, 32'sh80000000);
    wait_drained();

    // random phases with several settings
    reg_write(REG_START_X, $urandom);
    reg_write(REG_STEP_SIZE, $urandom_range(32'h0002_0000, 1));
    reg_write(REG_STEP_COUNT, $urandom_range(6, 1));
    queue_random(110);
    wait_drained();

    send_idle_pct = 62;
    recv_idle_pct = 22;
    reg_write(REG_START_X, $urandom);
    reg_write(REG_STEP_SIZE, $urandom_range(32'h0000_4000, 1));
    reg_write(REG_STEP_COUNT, $urandom_range(4, 1));
    queue_random(110);
    // long receiver hold-off while problems keep coming
    repeat (300) @(posedge clk);
    @(negedge clk);
    hold_cycles = 2000;
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(REG_STEP_SIZE, $urandom);
    reg_write(REG_STEP_COUNT, $urandom_range(3, 0));
    queue_random(40);
    wait_drained();
    reg_write(REG_STEP_SIZE, 32'd6554);
    reg_write(REG_STEP_COUNT, 32'd32);
    queue_random(60);
    wait_drained();

    $display("ran %0d problems, %0d result words checked across register settings",
             problems_sent, words_seen);
    $display("covered zero and saturated step counts, step size extremes, equal guesses");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
